/* rtl/core/hex_pair_line_parser_defines.svh */
// ----------------------------------------------------------------------------
// hex_pair_line_parser_defines
// assertion macros shared by the line parser modules
// ----------------------------------------------------------------------------
`ifndef HEX_PAIR_LINE_PARSER_DEFINES_SVH
`define HEX_PAIR_LINE_PARSER_DEFINES_SVH

// property that holds at every clock edge out of reset
`define HPLP_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// property that holds in the cycle after its trigger
`define HPLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hplp_pkg.sv */
// ----------------------------------------------------------------------------
// hplp_pkg
// types, status codes and helper functions of the hex pair line parser
// ----------------------------------------------------------------------------
`default_nettype none

package hplp_pkg;

	localparam int MAX_REQ_BYTES_DEF  = 16;
	localparam int MAX_RESP_BYTES_DEF = 16;
	localparam int OQ_DEPTH           = 4;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_EQ  = 8'h3d;
	localparam logic [7:0] CH_NL  = 8'h0a;

	localparam logic [3:0] ST_OK             = 4'd0;
	localparam logic [3:0] ST_EMPTY          = 4'd1;
	localparam logic [3:0] ST_NO_SEP         = 4'd2;
	localparam logic [3:0] ST_REQ_EMPTY      = 4'd3;
	localparam logic [3:0] ST_REQ_TOO_LONG   = 4'd4;
	localparam logic [3:0] ST_REQ_ODD        = 4'd5;
	localparam logic [3:0] ST_REQ_BAD_DIGIT  = 4'd6;
	localparam logic [3:0] ST_RESP_EMPTY     = 4'd7;
	localparam logic [3:0] ST_RESP_TOO_LONG  = 4'd8;
	localparam logic [3:0] ST_RESP_ODD       = 4'd9;
	localparam logic [3:0] ST_RESP_BAD_DIGIT = 4'd10;

	typedef struct packed {
		logic       kind;
		logic       part;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [3:0] status;
		logic [4:0] req_len;
		logic [4:0] resp_len;
		logic       end_mark;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] v;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.v  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.v = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [3:0] part_status(input logic [7:0] digits, input logic bad,
		input logic [7:0] lim, input logic is_resp);
		logic [3:0] st;
		if (digits == 8'd0) begin
			st = is_resp ? ST_RESP_EMPTY : ST_REQ_EMPTY;
		end else if (digits > lim) begin
			st = is_resp ? ST_RESP_TOO_LONG : ST_REQ_TOO_LONG;
		end else if (digits[0]) begin
			st = is_resp ? ST_RESP_ODD : ST_REQ_ODD;
		end else if (bad) begin
			st = is_resp ? ST_RESP_BAD_DIGIT : ST_REQ_BAD_DIGIT;
		end else begin
			st = ST_OK;
		end
		return st;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/hex_pair_line_parser.sv */
// ----------------------------------------------------------------------------
// hex_pair_line_parser
// parses a hexrequest=hexresponse line one character per transfer
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   ch, has_char, last
//  result    out        out_valid / out_ready kind, part, byte_index,
//                                             byte_value, status, req_len,
//                                             resp_len, end_mark
//
// one character per cycle while the queue has room; a result passes the input register, then the queue
// the input register feeds combinational step logic into a four entry queue
// a character may give a byte and a status; the queue absorbs the extra one
// input stalls only while the queue holds more than two results
// reset returns the parser to the start of a line
// ----------------------------------------------------------------------------
`default_nettype none

module hex_pair_line_parser #(
	parameter int MAX_REQ_BYTES  = hplp_pkg::MAX_REQ_BYTES_DEF,
	parameter int MAX_RESP_BYTES = hplp_pkg::MAX_RESP_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       has_char,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic            part,
	output logic [3:0]      byte_index,
	output logic [7:0]      byte_value,
	output logic [3:0]      status,
	output logic [4:0]      req_len,
	output logic [4:0]      resp_len,
	output logic            end_mark
);
	import hplp_pkg::*;

	push_t push;
	logic  room;
	res_t  res;

	hplp_core #(
		.MAX_REQ_BYTES  (MAX_REQ_BYTES),
		.MAX_RESP_BYTES (MAX_RESP_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.has_char (has_char),
		.last     (last),
		.room     (room),
		.push     (push)
	);

	hplp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign kind       = res.kind;
	assign part       = res.part;
	assign byte_index = res.byte_index;
	assign byte_value = res.byte_value;
	assign status     = res.status;
	assign req_len    = res.req_len;
	assign resp_len   = res.resp_len;
	assign end_mark   = res.end_mark;

endmodule

`default_nettype wire

/* rtl/core/hplp_part.sv */
// ----------------------------------------------------------------------------
// hplp_part
// saturating digit counter and bad digit flag of one part of the line
// ----------------------------------------------------------------------------
`default_nettype none

module hplp_part #(
	parameter int MAX_BYTES = hplp_pkg::MAX_REQ_BYTES_DEF,
	parameter int DW        = $clog2(2 * MAX_BYTES + 2)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic          clear,
	input  wire logic          hex_ok,
	output logic [DW-1:0]      digits_nx,
	output logic               bad_nx,
	output logic               latch,
	output logic               emit,
	output logic [3:0]         idx
);
	import hplp_pkg::*;

	localparam logic [DW-1:0] LIM = DW'(2 * MAX_BYTES);

	logic [DW-1:0] digits_q;
	logic          bad_q;
	logic [DW-1:0] inc;
	logic          step;

	assign inc  = digits_q + DW'(1);
	assign step = take && !(digits_q > LIM);

	always_comb begin
		digits_nx = digits_q;
		bad_nx    = bad_q;
		latch     = 1'b0;
		emit      = 1'b0;
		if (step) begin
			digits_nx = inc;
			bad_nx    = bad_q | !hex_ok;
			latch     = inc[0];
			emit      = !inc[0] && !(inc > LIM);
		end
	end

	assign idx = 4'((inc >> 1) - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			bad_q    <= 1'b0;
		end else if (clear) begin
			digits_q <= '0;
			bad_q    <= 1'b0;
		end else begin
			digits_q <= digits_nx;
			bad_q    <= bad_nx;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hplp_outq.sv */
// ----------------------------------------------------------------------------
// hplp_outq
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "hex_pair_line_parser_defines.svh"

module hplp_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hplp_pkg::push_t push,
	output logic                room,
	output logic                out_valid,
	input  wire logic           out_ready,
	output hplp_pkg::res_t      out_res
);
	import hplp_pkg::*;

	localparam int AW = $clog2(OQ_DEPTH);
	localparam int CW = $clog2(OQ_DEPTH + 1);

	res_t          mem_q [OQ_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    n_push;

	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= CW'(OQ_DEPTH - 2);
	assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[AW'(wr_q + AW'(1))] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= AW'(wr_q + AW'(n_push));
			rd_q    <= rd_q + AW'(pop);
			count_q <= CW'(count_q + CW'(n_push) - CW'(pop));
		end
	end

	`HPLP_ASSERT(a_count_bound, count_q <= CW'(OQ_DEPTH), "result queue overfilled")
	`HPLP_ASSERT(a_push_order, !push.v1 || push.v0, "second slot written without first")
	`HPLP_ASSERT(a_push_room, !push.v0 || room, "result written without room")

endmodule

`default_nettype wire

/* rtl/core/hplp_core.sv */
// ----------------------------------------------------------------------------
// hplp_core
// input register, line state and per character step of the parser
// ----------------------------------------------------------------------------
`default_nettype none
`include "hex_pair_line_parser_defines.svh"

module hplp_core #(
	parameter int MAX_REQ_BYTES  = hplp_pkg::MAX_REQ_BYTES_DEF,
	parameter int MAX_RESP_BYTES = hplp_pkg::MAX_RESP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        has_char,
	input  wire logic        last,
	input  wire logic        room,
	output hplp_pkg::push_t  push
);
	import hplp_pkg::*;

	localparam int RQW = $clog2(2 * MAX_REQ_BYTES + 2);
	localparam int RSW = $clog2(2 * MAX_RESP_BYTES + 2);

	typedef enum logic [2:0] {
		PH_REQ  = 3'b001,
		PH_RESP = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       has_s1;
	logic       last_s1;

	phase_t     phase_q;
	phase_t     phase_nx;
	logic [3:0] held_q;
	logic       sep_off_q;
	logic       nl_off_q;
	logic       sep_off_nx;
	logic       nl_off_nx;

	logic       fire;
	logic       clear;
	hex_t       hx;
	logic       is_nul;
	logic       is_eq;
	logic       is_nl;
	logic       in_req;
	logic       in_resp;
	logic       nl_end;
	logic       req_take;
	logic       resp_take;

	logic [RQW-1:0] req_digits_nx;
	logic           req_bad_nx;
	logic           req_latch;
	logic           req_emit;
	logic [3:0]     req_idx;
	logic [RSW-1:0] resp_digits_nx;
	logic           resp_bad_nx;
	logic           resp_latch;
	logic           resp_emit;
	logic [3:0]     resp_idx;

	res_t       byte_res;
	res_t       stat_res;
	logic [3:0] st;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;
	assign clear    = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			has_s1  <= has_char;
			last_s1 <= last;
		end
	end

	// character classification
	assign hx      = hex_value(ch_s1);
	assign is_nul  = ch_s1 == CH_NUL;
	assign is_eq   = ch_s1 == CH_EQ;
	assign is_nl   = ch_s1 == CH_NL;
	assign in_req  = has_s1 && phase_q == PH_REQ && !sep_off_q;
	assign in_resp = has_s1 && phase_q == PH_RESP;
	assign nl_end  = in_resp && !nl_off_q && is_nl;

	assign req_take  = fire && in_req && !is_nul && !is_eq;
	assign resp_take = fire && in_resp && !nl_end;

	always_comb begin
		phase_nx   = phase_q;
		sep_off_nx = sep_off_q;
		nl_off_nx  = nl_off_q;
		if (in_req && is_nul) begin
			sep_off_nx = 1'b1;
		end else if (in_req && is_eq) begin
			phase_nx = PH_RESP;
		end
		if (nl_end) begin
			phase_nx = PH_DONE;
		end else if (in_resp && is_nul) begin
			nl_off_nx = 1'b1;
		end
	end

	hplp_part #(
		.MAX_BYTES (MAX_REQ_BYTES),
		.DW        (RQW)
	) u_req (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (req_take),
		.clear     (clear),
		.hex_ok    (hx.ok),
		.digits_nx (req_digits_nx),
		.bad_nx    (req_bad_nx),
		.latch     (req_latch),
		.emit      (req_emit),
		.idx       (req_idx)
	);

	hplp_part #(
		.MAX_BYTES (MAX_RESP_BYTES),
		.DW        (RSW)
	) u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (resp_take),
		.clear     (clear),
		.hex_ok    (hx.ok),
		.digits_nx (resp_digits_nx),
		.bad_nx    (resp_bad_nx),
		.latch     (resp_latch),
		.emit      (resp_emit),
		.idx       (resp_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_REQ;
			held_q    <= 4'd0;
			sep_off_q <= 1'b0;
			nl_off_q  <= 1'b0;
		end else if (clear) begin
			phase_q   <= PH_REQ;
			held_q    <= 4'd0;
			sep_off_q <= 1'b0;
			nl_off_q  <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_nx;
			sep_off_q <= sep_off_nx;
			nl_off_q  <= nl_off_nx;
			if (req_latch || resp_latch) begin
				held_q <= hx.v;
			end
		end
	end

	// closing status from the state after this character
	always_comb begin
		if (phase_nx == PH_REQ) begin
			st = (!sep_off_nx && req_digits_nx == '0) ? ST_EMPTY : ST_NO_SEP;
		end else begin
			st = part_status(8'(req_digits_nx), req_bad_nx, 8'(2 * MAX_REQ_BYTES), 1'b0);
			if (st == ST_OK) begin
				st = part_status(8'(resp_digits_nx), resp_bad_nx,
					8'(2 * MAX_RESP_BYTES), 1'b1);
			end
		end
	end

	always_comb begin
		byte_res            = '0;
		byte_res.part       = resp_emit;
		byte_res.byte_index = resp_emit ? resp_idx : req_idx;
		byte_res.byte_value = {held_q, hx.v};

		stat_res          = '0;
		stat_res.kind     = 1'b1;
		stat_res.status   = st;
		stat_res.end_mark = 1'b1;
		if (st == ST_OK) begin
			stat_res.req_len  = 5'(req_digits_nx >> 1);
			stat_res.resp_len = 5'(resp_digits_nx >> 1);
		end
	end

	always_comb begin
		push = '0;
		if (req_emit || resp_emit) begin
			push.v0 = 1'b1;
			push.r0 = byte_res;
			push.v1 = clear;
			push.r1 = stat_res;
		end else begin
			push.v0 = clear;
			push.r0 = stat_res;
		end
	end

	`HPLP_ASSERT_NEXT(a_line_restart, clear,
		phase_q == PH_REQ && !sep_off_q && !nl_off_q && held_q == 4'd0,
		"line state not cleared after closing transfer")
	`HPLP_ASSERT_NEXT(a_s1_hold, valid_s1 && !fire,
		valid_s1 && ch_s1 == $past(ch_s1) && last_s1 == $past(last_s1),
		"stalled character lost")

endmodule

`default_nettype wire

/* verif/tb_hex_pair_line_parser.sv */
// ----------------------------------------------------------------------------
// tb_hex_pair_line_parser
// self-checking bench for the hex pair line parser: lines of the form
// hexrequest=hexresponse are fed one character per transfer, a line
// tracker predicts every decoded byte and the closing status, and each
// result transfer is compared field by field against the oldest prediction;
// directed corner lines come first, then random lines under four phases
// of sender idling and receiver stalling
// ----------------------------------------------------------------------------

module tb_hex_pair_line_parser;

	import hplp_pkg::*;

	localparam int REQ_MAX      = MAX_REQ_BYTES_DEF;
	localparam int RESP_MAX     = MAX_RESP_BYTES_DEF;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS  = 175;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic PART_REQ    = 1'b0;
	localparam logic PART_RESP   = 1'b1;

	typedef enum logic [1:0] {AT_REQUEST, AT_RESPONSE, AT_END} line_phase_e;

	class parse_tracker;
		line_phase_e phase;
		logic [3:0]  held_nibble;
		logic [7:0]  req_digits;
		logic [7:0]  resp_digits;
		bit          req_bad;
		bit          resp_bad;
		bit          nl_search_off;
		bit          sep_search_off;
		res_t        pending_results[$];
		int          errors;
		int          n_bytes;
		int          n_status;
		int          n_lines;
		int          n_chars;
		bit [10:0]   statuses_hit;

		function new();
			clear_line();
		endfunction

		function void clear_line();
			phase          = AT_REQUEST;
			held_nibble    = 4'd0;
			req_digits     = 8'd0;
			resp_digits    = 8'd0;
			req_bad        = 1'b0;
			resp_bad       = 1'b0;
			nl_search_off  = 1'b0;
			sep_search_off = 1'b0;
		endfunction

		// counts one digit of a part, returns 1 when a byte is complete
		function bit digit_step(input logic [7:0] c, inout logic [7:0] digits,
			inout bit bad, input int maxb, output logic [7:0] val,
			output logic [3:0] idx);
			bit         is_hex;
			logic [3:0] nib;
			is_hex = 1'b1;
			nib    = 4'd0;
			val    = 8'd0;
			idx    = 4'd0;
			if (c >= "0" && c <= "9") begin
				nib = 4'(c - "0");
			end else if (c >= "a" && c <= "f") begin
				nib = 4'(c - "a" + 8'd10);
			end else if (c >= "A" && c <= "F") begin
				nib = 4'(c - "A" + 8'd10);
			end else begin
				is_hex = 1'b0;
			end
			if (digits > 2 * maxb)
				return 1'b0;
			if (!is_hex)
				bad = 1'b1;
			digits++;
			if (digits[0]) begin
				held_nibble = nib;
				return 1'b0;
			end
			if (digits > 2 * maxb)
				return 1'b0;
			val = {held_nibble, nib};
			idx = 4'(digits / 2 - 1);
			return 1'b1;
		endfunction

		function logic [3:0] verdict(input logic [7:0] digits, input bit bad,
			input int maxb, input bit is_resp);
			if (digits == 0)
				return is_resp ? ST_RESP_EMPTY : ST_REQ_EMPTY;
			if (digits > 2 * maxb)
				return is_resp ? ST_RESP_TOO_LONG : ST_REQ_TOO_LONG;
			if (digits[0])
				return is_resp ? ST_RESP_ODD : ST_REQ_ODD;
			if (bad)
				return is_resp ? ST_RESP_BAD_DIGIT : ST_REQ_BAD_DIGIT;
			return ST_OK;
		endfunction

		function void note_byte(input logic prt, input logic [3:0] idx,
			input logic [7:0] val);
			res_t r;
			r            = '0;
			r.kind       = KIND_BYTE;
			r.part       = prt;
			r.byte_index = idx;
			r.byte_value = val;
			pending_results.push_back(r);
		endfunction

		// accepted input transfer: advance the line state, queue what it yields
		function void take_char(input logic [7:0] c, input logic h, input logic l);
			res_t       r;
			logic [7:0] val;
			logic [3:0] idx;
			logic [3:0] st;
			if (h) begin
				n_chars++;
				if (phase == AT_REQUEST) begin
					if (!sep_search_off) begin
						if (c == CH_NUL)
							sep_search_off = 1'b1;
						else if (c == CH_EQ)
							phase = AT_RESPONSE;
						else if (digit_step(c, req_digits, req_bad, REQ_MAX, val, idx))
							note_byte(PART_REQ, idx, val);
					end
				end else if (phase == AT_RESPONSE) begin
					if (!nl_search_off && c == CH_NL) begin
						phase = AT_END;
					end else begin
						if (c == CH_NUL)
							nl_search_off = 1'b1;
						if (digit_step(c, resp_digits, resp_bad, RESP_MAX, val, idx))
							note_byte(PART_RESP, idx, val);
					end
				end
			end
			if (l) begin
				r          = '0;
				r.kind     = KIND_STATUS;
				r.end_mark = 1'b1;
				if (phase == AT_REQUEST) begin
					st = (!sep_search_off && req_digits == 0) ? ST_EMPTY : ST_NO_SEP;
				end else begin
					st = verdict(req_digits, req_bad, REQ_MAX, 1'b0);
					if (st == ST_OK)
						st = verdict(resp_digits, resp_bad, RESP_MAX, 1'b1);
					if (st == ST_OK) begin
						r.req_len  = 5'(req_digits / 2);
						r.resp_len = 5'(resp_digits / 2);
					end
				end
				r.status = st;
				pending_results.push_back(r);
				n_lines++;
				clear_line();
			end
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch: %s", msg);
		endtask

		task cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d %s is %0h, expected %0h",
					n_bytes + n_status, name, got, want));
		endtask

		// accepted result transfer against the oldest prediction
		task check_result(input res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result %h with nothing pending", got));
				return;
			end
			want = pending_results.pop_front();
			cmp_field("kind", got.kind, want.kind);
			cmp_field("part", got.part, want.part);
			cmp_field("byte_index", got.byte_index, want.byte_index);
			cmp_field("byte_value", got.byte_value, want.byte_value);
			cmp_field("status", got.status, want.status);
			cmp_field("req_len", got.req_len, want.req_len);
			cmp_field("resp_len", got.resp_len, want.resp_len);
			cmp_field("end_mark", got.end_mark, want.end_mark);
			if (want.kind == KIND_STATUS) begin
				n_status++;
				statuses_hit[want.status] = 1'b1;
			end else begin
				n_bytes++;
			end
		endtask
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] ch        = 8'h00;
	logic       has_char  = 1'b0;
	logic       last      = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic       part;
	logic [3:0] byte_index;
	logic [7:0] byte_value;
	logic [3:0] status;
	logic [4:0] req_len;
	logic [4:0] resp_len;
	logic       end_mark;
	res_t       seen;

	parse_tracker sb = new();
	int send_idle_pct  = 0;
	int resp_stall_pct = 0;
	int items_sent     = 0;
	int quiet_cycles   = 0;

	hex_pair_line_parser dut (.*);

	assign seen = {kind, part, byte_index, byte_value, status, req_len, resp_len, end_mark};

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(seen);
		out_ready <= ($urandom_range(99) >= resp_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results pending",
				quiet_cycles, sb.pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic put_item(input logic [7:0] c, input logic h, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		has_char <= h;
		last     <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_char(c, h, l);
		if (h || l)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_item(s[i], 1'b1, i == s.len() - 1);
	endtask

	function automatic logic [7:0] hex_digit();
		string digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(21)];
	endfunction

	function automatic logic [7:0] noisy_char();
		case ($urandom_range(4))
			0: return CH_EQ;
			1: return CH_NL;
			2: return CH_NUL;
			3: return hex_digit();
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly short parts, a few up to and past the limit
	function automatic int pick_len(input int maxb);
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 4);
		if (r < 92)
			return $urandom_range(5, maxb);
		return $urandom_range(0, maxb + 2);
	endfunction

	task automatic send_random_line();
		logic [7:0] text[$];
		int         nreq;
		int         nresp;
		int         sep_pos;
		bit         split_close;
		if ($urandom_range(99) < 75) begin
			nreq  = pick_len(REQ_MAX);
			nresp = pick_len(RESP_MAX);
			repeat (2 * nreq)
				text.push_back(hex_digit());
			if ($urandom_range(9) == 0 && text.size() > 0)
				void'(text.pop_back());
			text.push_back(CH_EQ);
			sep_pos = text.size();
			repeat (2 * nresp)
				text.push_back(hex_digit());
			if ($urandom_range(9) == 0 && text.size() > sep_pos)
				void'(text.pop_back());
			if ($urandom_range(11) == 0)
				text.insert($urandom_range(sep_pos, text.size()), CH_NUL);
			if ($urandom_range(11) == 0)
				text[$urandom_range(text.size() - 1)] = noisy_char();
			if ($urandom_range(1)) begin
				text.push_back(CH_NL);
				repeat ($urandom_range(3))
					text.push_back(noisy_char());
			end
		end else begin
			repeat ($urandom_range(8))
				text.push_back(noisy_char());
		end
		split_close = (text.size() == 0) || ($urandom_range(3) == 0);
		foreach (text[i]) begin
			if ($urandom_range(24) == 0)
				put_item(8'($urandom), 1'b0, 1'b0);
			put_item(text[i], 1'b1, !split_close && i == text.size() - 1);
		end
		if (split_close)
			put_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int phase_end;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// corner lines
		put_item(8'h00, 1'b0, 1'b1);
		put_item(8'hff, 1'b0, 1'b0);
		put_item(CH_EQ, 1'b1, 1'b1);
		put_item(CH_NUL, 1'b1, 1'b1);
		send_text("12");
		send_text("0f=9A\nZ");
		put_item("1", 1'b1, 1'b0);
		put_item(CH_EQ, 1'b1, 1'b0);
		put_item(CH_NUL, 1'b1, 1'b0);
		put_item(8'hff, 1'b1, 1'b0);
		put_item(CH_NL, 1'b1, 1'b1);
		send_text("ab=c=");

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					resp_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					resp_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					resp_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 12;
					resp_stall_pct = 12;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_line();
		end

		in_valid       <= 1'b0;
		resp_stall_pct = 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d lines, %0d characters: %0d byte results and %0d status results checked",
			sb.n_lines, sb.n_chars, sb.n_bytes, sb.n_status);
		$display("%0d of 11 status codes reached, %0d mismatches",
			$countones(sb.statuses_hit), sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
